// ===== src/tdsm_pkg.sv =====
package tdsm_pkg;

  // command codes
  localparam logic [2:0] OP_DEC   = 3'd0;
  localparam logic [2:0] OP_HEX   = 3'd1;
  localparam logic [2:0] OP_CHR   = 3'd2;
  localparam logic [2:0] OP_BLANK = 3'd3;
  localparam logic [2:0] OP_TICK  = 3'd4;

  // status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_REJ = 1'b1;

  // segment constants
  localparam logic [7:0] GLYPH_ZERO    = 8'b0011_1111;
  localparam logic [7:0] GLYPH_EIGHT   = 8'b0111_1111;
  localparam logic [7:0] GLYPH_MINUS   = 8'b0100_0000;
  localparam logic [7:0] GLYPH_FIVE    = 8'b0110_1101;
  localparam logic [7:0] GLYPH_BLANK   = 8'h00;
  localparam logic [7:0] BLANKED_FRAME = 8'hFF;
  localparam logic [3:0] NIBBLE_MASK   = 4'hF;

  // decimal range accepted by the show-decimal command
  localparam logic signed [7:0] DEC_MIN = -8'sd9;
  localparam logic signed [7:0] DEC_MAX = 8'sd99;

  // ascii codes that need special handling
  localparam logic [7:0] CHAR_NUL = 8'h00;

  // hex digit glyphs, lowercase b and d
  function automatic logic [7:0] hex_glyph(input logic [3:0] nib);
    logic [7:0] g;
    unique case (nib)
      4'h0: g = GLYPH_ZERO;
      4'h1: g = 8'h06;
      4'h2: g = 8'h5B;
      4'h3: g = 8'h4F;
      4'h4: g = 8'h66;
      4'h5: g = GLYPH_FIVE;
      4'h6: g = 8'h7D;
      4'h7: g = 8'h07;
      4'h8: g = GLYPH_EIGHT;
      4'h9: g = 8'h6F;
      4'hA: g = 8'h77;
      4'hB: g = 8'h7C;
      4'hC: g = 8'h39;
      4'hD: g = 8'h5E;
      4'hE: g = 8'h79;
      default: g = 8'h71;
    endcase
    return g;
  endfunction

  // ascii character to segment pattern, unmapped codes blank
  function automatic logic [7:0] char_glyph(input logic [7:0] code);
    logic [7:0] g;
    unique case (code) inside
      8'h30, 8'h4F:         g = GLYPH_ZERO;   // '0' 'O'
      8'h31:                g = 8'h06;
      8'h32:                g = 8'h5B;
      8'h33:                g = 8'h4F;
      8'h34:                g = 8'h66;
      8'h35, 8'h53, 8'h73:  g = GLYPH_FIVE;   // '5' 'S' 's'
      8'h36:                g = 8'h7D;
      8'h37:                g = 8'h07;
      8'h38:                g = GLYPH_EIGHT;
      8'h39:                g = 8'h6F;
      8'h41, 8'h61:         g = 8'h77;        // 'A' 'a'
      8'h62:                g = 8'h7C;        // 'b'
      8'h43:                g = 8'h39;        // 'C'
      8'h63:                g = 8'h58;        // 'c'
      8'h64:                g = 8'h5E;        // 'd'
      8'h45, 8'h65:         g = 8'h79;        // 'E' 'e'
      8'h46, 8'h66:         g = 8'h71;        // 'F' 'f'
      8'h48:                g = 8'h76;        // 'H'
      8'h68:                g = 8'h74;        // 'h'
      8'h4C, 8'h6C:         g = 8'h38;        // 'L' 'l'
      8'h6E:                g = 8'h54;        // 'n'
      8'h6F:                g = 8'h5C;        // 'o'
      8'h50, 8'h70:         g = 8'h73;        // 'P' 'p'
      8'h55:                g = 8'h3E;        // 'U'
      8'h75:                g = 8'h1C;        // 'u'
      8'h2D:                g = GLYPH_MINUS;  // '-'
      8'h5F:                g = 8'h08;        // '_'
      default:              g = GLYPH_BLANK;
    endcase
    return g;
  endfunction

endpackage

// ===== src/tdsm_if.sv =====
// command channel
interface tdsm_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        op;
  logic signed [7:0] number;
  logic [7:0]        hex_byte;
  logic [7:0]        first_char;
  logic [7:0]        second_char;

  modport source (output valid, output op, output number, output hex_byte,
                  output first_char, output second_char, input ready);
  modport sink   (input valid, input op, input number, input hex_byte,
                  input first_char, input second_char, output ready);
endinterface

// result channel
interface tdsm_out_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic       frame_valid;
  logic [7:0] frame;

  modport source (output valid, output status, output frame_valid, output frame,
                  input ready);
  modport sink   (input valid, input status, input frame_valid, input frame,
                  output ready);
endinterface

// ===== src/two_digit_seven_segment_mux_core.sv =====
// two-digit multiplexed seven-segment driver
// each accepted command word yields its result word in the result register on the next cycle
// throughput: one word per cycle, set by the single result register; a new
// word is taken while the result register is empty or being drained
// reset: synchronous active-low rst_n clears the digit patterns to blank,
// turns the display off, selects the left digit and empties the result register
module two_digit_seven_segment_mux_core (
  input  logic        clk,
  input  logic        rst_n,
  tdsm_in_if.sink     in_ch,
  tdsm_out_if.source  out_ch
);
  import tdsm_pkg::*;

  // display state
  logic [7:0] pat_r [2];
  logic [7:0] pat_nxt [2];
  logic       disp_on_r, disp_on_nxt;
  logic       act_r, act_nxt;

  // result register
  logic       out_valid_r, out_valid_nxt;
  logic       status_r, status_nxt;
  logic       fvalid_r, fvalid_nxt;
  logic [7:0] frame_r, frame_nxt;

  logic       accept;
  logic       in_range;
  logic [6:0] mag;
  logic [14:0] tens_prod;
  logic [3:0] tens;
  logic [3:0] ones;
  logic       show_right;
  logic [7:0] shown;

  // take a new word whenever the result register is free or draining
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  // decimal split: magnitude, tens by reciprocal multiply, ones by remainder
  assign in_range  = (in_ch.number >= DEC_MIN) && (in_ch.number <= DEC_MAX);
  assign mag       = in_ch.number[7] ? 7'(-in_ch.number) : in_ch.number[6:0];
  assign tens_prod = {8'd0, mag} * 15'd205;
  assign tens      = tens_prod[14:11];
  assign ones      = 4'(mag - 7'(tens) * 7'd10);

  // refresh frame selects the toggled digit
  assign show_right = ~act_r;
  assign shown      = pat_r[show_right];

  // command decode
  always_comb begin
    pat_nxt       = pat_r;
    disp_on_nxt   = disp_on_r;
    act_nxt       = act_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    status_nxt    = status_r;
    fvalid_nxt    = fvalid_r;
    frame_nxt     = frame_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      status_nxt    = STATUS_OK;
      fvalid_nxt    = 1'b0;
      frame_nxt     = 8'h00;
      unique case (in_ch.op)
        OP_DEC: begin
          if (!in_range) begin
            status_nxt = STATUS_REJ;
          end else if (in_ch.number[7]) begin
            pat_nxt[0]  = GLYPH_MINUS;
            pat_nxt[1]  = hex_glyph(ones);
            disp_on_nxt = 1'b1;
          end else begin
            pat_nxt[0]  = (tens == 4'd0) ? GLYPH_BLANK : hex_glyph(tens);
            pat_nxt[1]  = hex_glyph(ones);
            disp_on_nxt = 1'b1;
          end
        end
        OP_HEX: begin
          pat_nxt[0]  = hex_glyph(in_ch.hex_byte[7:4] & NIBBLE_MASK);
          pat_nxt[1]  = hex_glyph(in_ch.hex_byte[3:0] & NIBBLE_MASK);
          disp_on_nxt = 1'b1;
        end
        OP_CHR: begin
          if (in_ch.first_char == CHAR_NUL) begin
            status_nxt = STATUS_REJ;
          end else begin
            pat_nxt[0]  = char_glyph(in_ch.first_char);
            pat_nxt[1]  = (in_ch.second_char != CHAR_NUL) ?
                          char_glyph(in_ch.second_char) : GLYPH_BLANK;
            disp_on_nxt = 1'b1;
          end
        end
        OP_BLANK: begin
          disp_on_nxt = 1'b0;
        end
        OP_TICK: begin
          fvalid_nxt = 1'b1;
          if (!disp_on_r) begin
            frame_nxt = BLANKED_FRAME;
          end else begin
            act_nxt   = show_right;
            frame_nxt = {show_right, ~shown[6:0]};
          end
        end
        default: begin
          status_nxt = STATUS_REJ;
        end
      endcase
    end
  end

  // state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r[0]    <= GLYPH_BLANK;
      pat_r[1]    <= GLYPH_BLANK;
      disp_on_r   <= 1'b0;
      act_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pat_r       <= pat_nxt;
      disp_on_r   <= disp_on_nxt;
      act_r       <= act_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    fvalid_r <= fvalid_nxt;
    frame_r  <= frame_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.frame_valid = fvalid_r;
  assign out_ch.frame       = frame_r;

endmodule
